### sv/block_bitmap_allocator_core_macros.svh
// Assertion helpers for the bitmap allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bba_pkg.sv
package bba_pkg;

  localparam int BLK_W    = 15;
  localparam int FUNC_W   = 2;
  localparam int SECT_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int BIDX_W   = 12;  // byte index taken from a block number
  localparam int CFG_W    = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_W-1:0]  CFG_SECS_RESET = 4'd8;
  localparam logic [BYTE_W-1:0] BYTE_FULL      = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_EMPTY     = 8'h00;

  localparam logic [FUNC_W-1:0] FUNC_TEST    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd3;

  typedef struct packed {
    logic [SECT_W-1:0] changed_sector;
    logic              sector_changed;
    logic              none_free;
    logic [BLK_W-1:0]  found_block;
    logic              is_free;
  } res_t;

endpackage

### sv/block_bitmap_allocator_core.sv
// Block bitmap allocator: one bit per data block (1 = used) held in a byte-wide
// synchronous RAM of MAP_SECTORS*SECTOR_BYTES bytes. Requests are test, find
// first free, assign and release; every request gives exactly one result.
// After reset the core runs a clearing pass over the RAM (4096 bytes by default),
// one byte per cycle, and takes no request until it ends; configuration writes
// are taken throughout. Requests are served one at a time. Test, assign and
// release pass through read, modify/write and result register; a request outside
// the map goes straight to the result. Find scans one map byte per cycle through
// the RAM read port, up to min(map_sectors_in_use, MAP_SECTORS)*SECTOR_BYTES
// bytes. A new request is accepted while the previous result still waits on the
// output.
`include "block_bitmap_allocator_core_macros.svh"

module block_bitmap_allocator_core #(
  parameter int MAP_SECTORS  = 8,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // [1:0] func, [16:2] block_index
  input  logic [bba_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] is_free, [15:1] found_block, [16] none_free, [17] sector_changed,
  // [20:18] changed_sector
  output logic [bba_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [bba_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int MAP_BYTES = MAP_SECTORS * SECTOR_BYTES;
  localparam int AW        = $clog2(MAP_BYTES);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [AW-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic [bba_pkg::CFG_W-1:0]     cfg_secs_r;
  logic [bba_pkg::FUNC_W-1:0]    func_r, func_nxt;
  logic [bba_pkg::BLK_W-1:0]     blk_r, blk_nxt;
  logic [AW:0]                   limit_r, limit_nxt;
  logic [AW:0]                   issue_r, issue_nxt;
  logic [AW-1:0]                 chk_r, chk_nxt;
  logic                          pend_r, pend_nxt;
  bba_pkg::res_t                 res_r, res_nxt;
  bba_pkg::res_t                 out_res_r, out_res_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [bba_pkg::BYTE_W-1:0]    mem_wdata, mem_rdata;
  logic [bba_pkg::SECT_W-1:0]    sector;

  logic [bba_pkg::FUNC_W-1:0]    in_func;
  logic [bba_pkg::BLK_W-1:0]     in_blk;
  logic                          in_fire, in_map;
  logic [bba_pkg::CFG_W-1:0]     secs;
  logic [bba_pkg::BYTE_W-1:0]    bit_mask;
  logic                          hit, issuing;
  logic [2:0]                    zero_pos;
  logic [31:0]                   found_full;
  logic [3:0]                    res_kinds;
  logic                          sect_clean;

  assign in_func   = in_tdata[1:0];
  assign in_blk    = in_tdata[16:2];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_map    = 32'(in_blk[14:3]) < 32'(MAP_BYTES);
  assign secs      = (32'(cfg_secs_r) > 32'(MAP_SECTORS)) ?
                     bba_pkg::CFG_W'(MAP_SECTORS) : cfg_secs_r;
  assign bit_mask  = bba_pkg::BYTE_W'(1) << blk_r[2:0];
  assign issuing   = (issue_r < limit_r);
  assign hit       = pend_r && (mem_rdata != bba_pkg::BYTE_FULL);

  // lowest clear bit of the byte under check
  always_comb begin
    zero_pos = 3'd0;
    for (int k = bba_pkg::BYTE_W - 1; k >= 0; k--) begin
      if (!mem_rdata[k]) begin
        zero_pos = 3'(k);
      end
    end
  end

  assign found_full = (32'(chk_r) << 3) | 32'(zero_pos);

  bba_mem #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bba_sect #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_sect (
    .clk     (clk),
    .byte_ix (blk_r[14:3]),
    .sector  (sector)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    func_nxt    = func_r;
    blk_nxt     = blk_r;
    limit_nxt   = limit_r;
    issue_nxt   = issue_r;
    chk_nxt     = chk_r;
    pend_nxt    = 1'b0;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = AW'(blk_r[14:3]);
    mem_wdata   = bba_pkg::BYTE_EMPTY;
    mem_re      = 1'b0;
    mem_raddr   = AW'(blk_r[14:3]);
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (32'(clr_cnt_r) == 32'(MAP_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_func;
          blk_nxt   = in_blk;
          limit_nxt = (AW+1)'(32'(secs) * 32'(SECTOR_BYTES));
          issue_nxt = '0;
          res_nxt   = '0;
          if (in_func == bba_pkg::FUNC_FIND) begin
            if (secs == '0) begin
              res_nxt.none_free = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else if (in_map) begin
            state_nxt = ST_RD;
          end else begin
            // outside the map: all-zero result
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (func_r == bba_pkg::FUNC_TEST) begin
          res_nxt.is_free = !mem_rdata[blk_r[2:0]];
        end else begin
          mem_we    = 1'b1;
          mem_wdata = (func_r == bba_pkg::FUNC_ASSIGN) ? (mem_rdata | bit_mask)
                                                       : (mem_rdata & ~bit_mask);
          res_nxt.sector_changed = 1'b1;
          res_nxt.changed_sector = sector;
        end
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (hit) begin
          // no further read is issued; report the lowest free block of this byte
          res_nxt.found_block = found_full[bba_pkg::BLK_W-1:0];
          state_nxt = ST_DONE;
        end else if (issuing) begin
          mem_re    = 1'b1;
          mem_raddr = issue_r[AW-1:0];
          chk_nxt   = issue_r[AW-1:0];
          issue_nxt = issue_r + (AW+1)'(1);
          pend_nxt  = 1'b1;
        end else begin
          res_nxt.none_free = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      cfg_secs_r  <= bba_pkg::CFG_SECS_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_secs_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    blk_r     <= blk_nxt;
    limit_r   <= limit_nxt;
    issue_r   <= issue_nxt;
    chk_r     <= chk_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  assign res_kinds  = {out_res_r.is_free, out_res_r.none_free, out_res_r.sector_changed,
                       (|out_res_r.found_block)};
  assign sect_clean = out_res_r.sector_changed || (out_res_r.changed_sector == '0);

  `BBA_ASSERT_NOW(a_mem_one_access, 1'b1, !(mem_we && mem_re), "RAM read and write in one cycle")
  `BBA_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != ST_IDLE, "accept did not start work")
  `BBA_ASSERT_NOW(a_one_result_kind, out_tvalid, $countones(res_kinds) <= 1, "mixed result fields")
  `BBA_ASSERT_NOW(a_sector_zero, out_tvalid, sect_clean, "sector reported without change")

endmodule

### sv/bba_mem.sv
module bba_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bba_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bba_pkg::BYTE_W-1:0] rdata
);

  logic [bba_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bba_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bba_sect.sv
// Map sector of a byte index: multiply by a rounded-up reciprocal of the sector
// size. With a 25-bit scale the quotient is exact for every 12-bit byte index.
module bba_sect #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic                       clk,
  input  logic [bba_pkg::BIDX_W-1:0] byte_ix,
  output logic [bba_pkg::SECT_W-1:0] sector
);

  localparam int SCALE   = 25;
  localparam int RECIP_W = 26;
  localparam int PROD_W  = RECIP_W + bba_pkg::BIDX_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SCALE) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES));

  logic [PROD_W-1:0]          prod;
  logic [bba_pkg::SECT_W-1:0] sector_r;

  assign prod = PROD_W'(byte_ix) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    sector_r <= prod[SCALE +: bba_pkg::SECT_W];
  end

  assign sector = sector_r;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MAP_SECTORS  = 8;
  localparam int SECTOR_BYTES = 512;
  localparam int MAP_BYTES    = MAP_SECTORS * SECTOR_BYTES;
  localparam logic [bba_pkg::BLK_W-1:0] LAST_BLOCK = 15'h7FFF;
  localparam bba_pkg::res_t NO_PIN = '0;
  // Clearing pass plus all finds, each up to a whole-map scan, with stalls, taken several times over
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [bba_pkg::FUNC_W-1:0] func;
    logic [bba_pkg::BLK_W-1:0]  blk;
    logic                       pinned;
    bba_pkg::res_t              res;
  } req_row_t;

  logic                            clk;
  logic                            rst_n;
  logic [bba_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bba_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic                            cfg_we;
  logic [bba_pkg::CFG_W-1:0]       cfg_wdata;

  // fixed expectation travelling with the request on the input side
  logic          pin_valid;
  bba_pkg::res_t pin_res;

  logic [bba_pkg::BYTE_W-1:0] block_used [MAP_BYTES];
  logic [bba_pkg::CFG_W-1:0]  sectors_searched;
  bba_pkg::res_t              pending_results [$];
  req_row_t                   directed_rows [$];
  int                         held_blocks [$];

  int errors = 0;
  int cycles = 0;
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_rcv;
  int n_func [4] = '{default: 0};
  int n_none_free = 0;
  int n_results = 0;

  block_bitmap_allocator_core #(
    .MAP_SECTORS (MAP_SECTORS),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bba_pkg::res_t mk_res(input logic fr, input logic [bba_pkg::BLK_W-1:0] fb,
                                           input logic nf, input logic sc,
                                           input logic [bba_pkg::SECT_W-1:0] cs);
    bba_pkg::res_t r;
    r.is_free        = fr;
    r.found_block    = fb;
    r.none_free      = nf;
    r.sector_changed = sc;
    r.changed_sector = cs;
    return r;
  endfunction

  function automatic void add_row(input logic [bba_pkg::FUNC_W-1:0] func,
                                  input logic [bba_pkg::BLK_W-1:0] blk, input logic pinned,
                                  input bba_pkg::res_t res);
    req_row_t row;
    row.func   = func;
    row.blk    = blk;
    row.pinned = pinned;
    row.res    = res;
    directed_rows.push_back(row);
  endfunction

  // lowest free block among the sectors searched, -1 when all are used
  function automatic int first_free_block();
    int lim;
    int i;
    int j;
    lim = (sectors_searched > MAP_SECTORS) ? MAP_SECTORS : int'(sectors_searched);
    lim = lim * SECTOR_BYTES;
    for (i = 0; i < lim; i++) begin
      if (block_used[i] != bba_pkg::BYTE_FULL) begin
        for (j = 0; j < 8; j++) begin
          if (!block_used[i][j]) return i * 8 + j;
        end
      end
    end
    return -1;
  endfunction

  function automatic bba_pkg::res_t serve_request(input logic [bba_pkg::FUNC_W-1:0] func,
                                                  input logic [bba_pkg::BLK_W-1:0] blk);
    bba_pkg::res_t r;
    int            fb;
    r = '0;
    unique case (func)
      bba_pkg::FUNC_TEST: begin
        r.is_free = ~block_used[blk[bba_pkg::BLK_W-1:3]][blk[2:0]];
      end
      bba_pkg::FUNC_FIND: begin
        fb = first_free_block();
        if (fb < 0) r.none_free = 1'b1;
        else r.found_block = fb[bba_pkg::BLK_W-1:0];
      end
      bba_pkg::FUNC_ASSIGN, bba_pkg::FUNC_RELEASE: begin
        block_used[blk[bba_pkg::BLK_W-1:3]][blk[2:0]] = (func == bba_pkg::FUNC_ASSIGN);
        r.sector_changed = 1'b1;
        r.changed_sector = blk[bba_pkg::BLK_W-1:bba_pkg::BLK_W-bba_pkg::SECT_W];
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bba_pkg::res_t              want;
    bba_pkg::res_t              got;
    logic [bba_pkg::FUNC_W-1:0] func;
    logic [bba_pkg::BLK_W-1:0]  blk;
    if (!rst_n) begin
      foreach (block_used[k]) block_used[k] = bba_pkg::BYTE_EMPTY;
      sectors_searched = bba_pkg::CFG_SECS_RESET;
    end else begin
      if (cfg_we) sectors_searched = cfg_wdata;
      if (in_tvalid && in_tready) begin
        func = in_tdata[bba_pkg::FUNC_W-1:0];
        blk  = in_tdata[bba_pkg::FUNC_W+bba_pkg::BLK_W-1:bba_pkg::FUNC_W];
        want = serve_request(func, blk);
        n_func[func]++;
        if (want.none_free) n_none_free++;
        pending_results.push_back(pin_valid ? pin_res : want);
      end
      if (out_tvalid && out_tready) begin
        got = bba_pkg::res_t'(out_tdata[$bits(bba_pkg::res_t)-1:0]);
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          check_field("is_free", int'(want.is_free), int'(got.is_free));
          check_field("found_block", int'(want.found_block), int'(got.found_block));
          check_field("none_free", int'(want.none_free), int'(got.none_free));
          check_field("sector_changed", int'(want.sector_changed), int'(got.sector_changed));
          check_field("changed_sector", int'(want.changed_sector), int'(got.changed_sector));
        end
      end
    end
  end

  // result side: random stalls, or a long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rcv > 0) begin
        out_tready <= 1'b0;
        hold_rcv = hold_rcv - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [bba_pkg::FUNC_W-1:0] func,
                          input logic [bba_pkg::BLK_W-1:0] blk,
                          input logic pinned, input bba_pkg::res_t res);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_tdata  <= {{(bba_pkg::IN_TDATA_W-bba_pkg::FUNC_W-bba_pkg::BLK_W){1'b0}}, blk, func};
    in_tvalid <= 1'b1;
    pin_valid <= pinned;
    pin_res   <= res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_sectors(input logic [bba_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly find-then-claim and release-then-probe sequences, some raw noise
  task automatic random_traffic(input int count);
    int sent;
    int pick;
    int fb;
    int idx;
    logic [bba_pkg::BLK_W-1:0] blk;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_req(bba_pkg::FUNC_FIND, bba_pkg::BLK_W'($urandom_range(32767)), 1'b0, NO_PIN);
        fb = first_free_block();
        blk = (fb < 0) ? bba_pkg::BLK_W'($urandom_range(32767)) : fb[bba_pkg::BLK_W-1:0];
        send_req(bba_pkg::FUNC_ASSIGN, blk, 1'b0, NO_PIN);
        if (fb >= 0) held_blocks.push_back(fb);
        sent += 2;
      end else if (pick < 75 && held_blocks.size() > 0) begin
        idx = $urandom_range(held_blocks.size() - 1);
        blk = bba_pkg::BLK_W'(held_blocks[idx]);
        held_blocks.delete(idx);
        send_req(bba_pkg::FUNC_RELEASE, blk, 1'b0, NO_PIN);
        send_req(bba_pkg::FUNC_TEST, blk, 1'b0, NO_PIN);
        send_req(bba_pkg::FUNC_FIND, bba_pkg::BLK_W'($urandom_range(32767)), 1'b0, NO_PIN);
        sent += 3;
      end else begin
        blk = ($urandom_range(1) != 0) ? bba_pkg::BLK_W'($urandom_range(32767))
                                       : bba_pkg::BLK_W'($urandom_range(63));
        send_req(bba_pkg::FUNC_W'($urandom_range(3)), blk, 1'b0, NO_PIN);
        sent += 1;
      end
    end
  endtask

  initial begin
    int i;
    int p;
    rst_n         = 1'b0;
    in_tdata      = '0;
    in_tvalid     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    pin_valid     = 1'b0;
    pin_res       = '0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_rcv      = 0;

    add_row(bba_pkg::FUNC_TEST,    15'd0,      1'b1, mk_res(1'b1, 15'd0, 1'b0, 1'b0, 3'd0));
    add_row(bba_pkg::FUNC_TEST,    LAST_BLOCK, 1'b1, mk_res(1'b1, 15'd0, 1'b0, 1'b0, 3'd0));
    add_row(bba_pkg::FUNC_FIND,    LAST_BLOCK, 1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b0, 3'd0));
    add_row(bba_pkg::FUNC_ASSIGN,  15'd0,      1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b1, 3'd0));
    // claiming a block already in use still reports the sector
    add_row(bba_pkg::FUNC_ASSIGN,  15'd0,      1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b1, 3'd0));
    add_row(bba_pkg::FUNC_TEST,    15'd0,      1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b0, 3'd0));
    add_row(bba_pkg::FUNC_FIND,    15'd0,      1'b1, mk_res(1'b0, 15'd1, 1'b0, 1'b0, 3'd0));
    add_row(bba_pkg::FUNC_ASSIGN,  LAST_BLOCK, 1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b1, 3'd7));
    add_row(bba_pkg::FUNC_TEST,    LAST_BLOCK, 1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b0, 3'd0));
    add_row(bba_pkg::FUNC_RELEASE, LAST_BLOCK, 1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b1, 3'd7));
    // releasing a block that is already free
    add_row(bba_pkg::FUNC_RELEASE, LAST_BLOCK, 1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b1, 3'd7));
    add_row(bba_pkg::FUNC_TEST,    LAST_BLOCK, 1'b1, mk_res(1'b1, 15'd0, 1'b0, 1'b0, 3'd0));
    for (i = 1; i < 8; i++) begin
      add_row(bba_pkg::FUNC_ASSIGN, 15'(i), 1'b0, NO_PIN);
    end
    // first byte now full: the scan has to step past it
    add_row(bba_pkg::FUNC_FIND,    15'd0,      1'b1, mk_res(1'b0, 15'd8, 1'b0, 1'b0, 3'd0));
    add_row(bba_pkg::FUNC_ASSIGN,  15'd4096,   1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b1, 3'd1));
    add_row(bba_pkg::FUNC_ASSIGN,  15'h5555,   1'b0, NO_PIN);
    add_row(bba_pkg::FUNC_TEST,    15'h2AAA,   1'b0, NO_PIN);
    add_row(bba_pkg::FUNC_RELEASE, 15'd0,      1'b0, NO_PIN);
    add_row(bba_pkg::FUNC_FIND,    15'h2AAA,   1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b0, 3'd0));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_sectors(bba_pkg::CFG_SECS_RESET);

    foreach (directed_rows[k]) begin
      send_req(directed_rows[k].func, directed_rows[k].blk, directed_rows[k].pinned,
               directed_rows[k].res);
    end
    wait_drain();

    // nothing to search: always reports no free block
    write_sectors(4'd0);
    send_req(bba_pkg::FUNC_FIND, 15'd0, 1'b1, mk_res(1'b0, 15'd0, 1'b1, 1'b0, 3'd0));
    wait_drain();
    // above the map size: clamps to the whole map
    write_sectors(4'd15);
    send_req(bba_pkg::FUNC_FIND, 15'd0, 1'b1, mk_res(1'b0, 15'd0, 1'b0, 1'b0, 3'd0));
    wait_drain();

    for (p = 0; p < 4; p++) begin
      unique case (p)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  write_sectors(4'd1); end
        1: begin snd_idle_pct = 63; rcv_stall_pct = 0;  write_sectors(4'd8); end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 63;
          write_sectors(bba_pkg::CFG_W'($urandom_range(7, 2)));
        end
        default: begin snd_idle_pct = 17; rcv_stall_pct = 17; write_sectors(4'd1); end
      endcase
      if (p == 2) hold_rcv = HOLD_CYCLES;
      random_traffic(14);
      // pause the input until everything in flight has come out
      if (p == 1) wait_drain();
      random_traffic(14);
      wait_drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d tests, %0d finds (%0d with no free block), %0d assigns, %0d releases",
             n_func[bba_pkg::FUNC_TEST], n_func[bba_pkg::FUNC_FIND], n_none_free,
             n_func[bba_pkg::FUNC_ASSIGN], n_func[bba_pkg::FUNC_RELEASE]);
    $display("Checked %0d results over search sizes 0, 1, 8, 15 and one in between",
             n_results);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
